// ===== src/ssd_ctm_pkg.sv =====
package ssd_ctm_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_SUBMIT = 2'd1,
        CMD_QUERY  = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_SIZE = 2'd2
    } status_t;

    // configuration register indexes
    localparam logic REG_CHANNELS = 1'b0;
    localparam logic REG_SPEED    = 1'b1;

    localparam int MAX_RESULTS = 32;
    localparam int MAX_SECTORS = 128;
    localparam int LAT_W       = 19;
    localparam int SPEED_W     = 16;
    localparam int PROD_W      = LAT_W + SPEED_W;
    localparam int unsigned NS_PER_S = 1000000000;

    // latency in ns per size class, index {sequential, write, class}
    localparam int unsigned LAT_TABLE [32] = '{
        NS_PER_S / 194672 * 100 / 1000, NS_PER_S / 189513 * 100 / 1000,
        NS_PER_S / 186798 * 100 / 1000, NS_PER_S / 176876 * 100 / 1000,
        NS_PER_S / 159182 * 100 / 1000, NS_PER_S / 141700 * 100 / 1000,
        NS_PER_S / 104546 * 100 / 1000, NS_PER_S / 66149 * 100 / 1000,
        NS_PER_S / 898 * 100 / 1000,    NS_PER_S / 899 * 100 / 1000,
        NS_PER_S / 898 * 100 / 1000,    NS_PER_S / 862 * 100 / 1000,
        NS_PER_S / 778 * 100 / 1000,    NS_PER_S / 795 * 100 / 1000,
        NS_PER_S / 450 * 100 / 1000,    NS_PER_S / 370 * 100 / 1000,
        NS_PER_S / 522101 * 100 / 1000, NS_PER_S / 488278 * 100 / 1000,
        NS_PER_S / 429834 * 100 / 1000, NS_PER_S / 371532 * 100 / 1000,
        NS_PER_S / 298845 * 100 / 1000, NS_PER_S / 281019 * 100 / 1000,
        NS_PER_S / 146861 * 100 / 1000, NS_PER_S / 71935 * 100 / 1000,
        NS_PER_S / 108649 * 100 / 1000, NS_PER_S / 104858 * 100 / 1000,
        NS_PER_S / 101045 * 100 / 1000, NS_PER_S / 87071 * 100 / 1000,
        NS_PER_S / 73645 * 100 / 1000,  NS_PER_S / 289488 * 100 / 1000,
        NS_PER_S / 143416 * 100 / 1000, NS_PER_S / 72945 * 100 / 1000
    };

endpackage

// ===== src/ssd_ctm_if.sv =====
interface ssd_ctm_req_if
    import ssd_ctm_pkg::*;
#(
    parameter int TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    command_t             command;
    logic [TIME_BITS-1:0] request_time;
    logic                 is_write;
    logic [31:0]          start_sector;
    logic [7:0]           sector_count;
    logic [31:0]          io_id;

    modport source (output valid, command, request_time, is_write, start_sector,
                    sector_count, io_id, input ready);
    modport sink (input valid, command, request_time, is_write, start_sector,
                  sector_count, io_id, output ready);
endinterface

interface ssd_ctm_rsp_if
    import ssd_ctm_pkg::*;
#(
    parameter int TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    status_t              status;
    logic                 was_sequential;
    logic [TIME_BITS-1:0] event_time;
    logic [31:0]          request_id;
    logic [5:0]           response_count;
    logic                 last;
    logic [31:0]          sequential_total;
    logic [31:0]          random_total;
    logic [31:0]          rollback_total;

    modport source (output valid, status, was_sequential, event_time, request_id,
                    response_count, last, sequential_total, random_total,
                    rollback_total, input ready);
    modport sink (input valid, status, was_sequential, event_time, request_id,
                  response_count, last, sequential_total, random_total,
                  rollback_total, output ready);
endinterface

interface ssd_ctm_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ssd_channel_timing_model_top.sv =====
// ssd channel timing model: takes one request at a time (clear, submit or query) and
// answers with one or more responses. submit and query walk the active channels one per
// cycle through a single compare unit. a submit runs scan, class check and latency lookup,
// 19x16 latency multiply, and saturating add and channel update; a query scans to find
// the next completion time, then walks the channels again to list the matching ids;
// a clear reports the totals and wipes the channels. response back-pressure can stall
// any step that loads a response. a new request is taken only once the previous one
// has been fully handled, though its final response may still sit in the output
// register. configuration writes are always accepted and should only be made while
// the block is idle. channel state is cleared at reset and by the clear command.
module ssd_channel_timing_model_top
    import ssd_ctm_pkg::*;
#(
    parameter int MAX_CHANNELS = 32,
    parameter int TIME_BITS    = 48
)
(
    input  logic                clk,
    input  logic                rst_n,
    ssd_ctm_req_if.sink         req,
    ssd_ctm_rsp_if.source       rsp,
    ssd_ctm_cfg_if.sink         cfg
);

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int K_W   = $clog2(MAX_RESULTS + 1);
    localparam int SUM_W = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_MUL,
        S_ADD,
        S_QSCAN,
        S_QEMIT,
        S_CLEAR
    } state_t;

    // per-channel state, valid bits stand in for the zero reset
    logic [TIME_BITS-1:0] done_mem [MAX_CHANNELS];
    logic [31:0]          id_mem   [MAX_CHANNELS];
    logic [32:0]          end_mem  [MAX_CHANNELS];
    logic                 wr_mem   [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] vld_reg;

    state_t               state_reg;
    logic [5:0]           chan_reg;
    logic [SPEED_W-1:0]   speed_reg;
    logic [TIME_BITS-1:0] frontier_reg;
    logic [31:0]          seq_cnt_reg;
    logic [31:0]          rand_cnt_reg;
    logic [31:0]          roll_cnt_reg;

    // latched request
    logic [TIME_BITS-1:0] time_reg;
    logic                 wr_reg;
    logic [31:0]          sector_reg;
    logic [7:0]           count_reg;
    logic [31:0]          id_reg;

    // scan unit
    logic [CNT_W-1:0]     scan_reg;
    logic                 found_reg;
    logic [TIME_BITS-1:0] best_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic                 seq_reg;
    logic [CNT_W-1:0]     tie_reg;
    logic [K_W-1:0]       k_reg;
    logic [K_W-1:0]       emit_cnt_reg;
    logic [LAT_W-1:0]     lat_reg;
    logic [PROD_W-1:0]    prod_reg;

    // response register
    logic                 rsp_valid_reg;
    status_t              rsp_status_reg;
    logic                 rsp_seq_reg;
    logic [TIME_BITS-1:0] rsp_time_reg;
    logic [31:0]          rsp_id_reg;
    logic [5:0]           rsp_count_reg;
    logic                 rsp_last_reg;
    logic [31:0]          rsp_seq_tot_reg;
    logic [31:0]          rsp_rand_tot_reg;
    logic [31:0]          rsp_roll_tot_reg;

    logic [CNT_W-1:0]     n_act;
    logic [IDX_W-1:0]     idx;
    logic [TIME_BITS-1:0] rd_done;
    logic [32:0]          rd_end;
    logic                 rd_wr;
    logic                 can_load;
    logic                 rsp_load;
    logic [2:0]           size_cls;
    logic [SUM_W-1:0]     sum;
    logic [TIME_BITS-1:0] done_time;
    logic [K_W-1:0]       k_next;
    logic [32:0]          end_next;

    // channels above the build limit act as the limit
    assign n_act = ({1'b0, chan_reg} > 7'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                         : CNT_W'(chan_reg);
    assign idx     = scan_reg[IDX_W-1:0];
    assign rd_done = vld_reg[idx] ? done_mem[idx] : '0;
    assign rd_end  = vld_reg[idx] ? end_mem[idx] : '0;
    assign rd_wr   = vld_reg[idx] ? wr_mem[idx] : 1'b0;

    // output slot free, or being emptied this cycle
    assign can_load = !rsp_valid_reg || rsp.ready;

    // a response goes into the output register this cycle
    assign rsp_load = can_load &&
        ((state_reg == S_CHECK &&
          (!found_reg || best_reg >= time_reg || count_reg > 8'(MAX_SECTORS))) ||
         state_reg == S_ADD || state_reg == S_CLEAR ||
         (state_reg == S_QSCAN && scan_reg == n_act && !found_reg) ||
         (state_reg == S_QEMIT && rd_done == best_reg));

    // smallest class c with count <= 2^c
    always_comb
    begin
        size_cls = '0;
        for (int c = 7; c >= 0; c--)
        begin
            if ({1'b0, count_reg} <= 9'(1 << c))
                size_cls = 3'(c);
        end
    end

    // completion time, saturating at the top of the time range
    assign sum       = SUM_W'(time_reg) + SUM_W'(prod_reg);
    assign done_time = (|sum[SUM_W-1:TIME_BITS]) ? '1 : sum[TIME_BITS-1:0];
    assign end_next  = {1'b0, sector_reg} + 33'(count_reg);

    assign k_next = (tie_reg > CNT_W'(MAX_RESULTS)) ? K_W'(MAX_RESULTS) : K_W'(tie_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = rsp_status_reg;
    assign rsp.was_sequential   = rsp_seq_reg;
    assign rsp.event_time       = rsp_time_reg;
    assign rsp.request_id       = rsp_id_reg;
    assign rsp.response_count   = rsp_count_reg;
    assign rsp.last             = rsp_last_reg;
    assign rsp.sequential_total = rsp_seq_tot_reg;
    assign rsp.random_total     = rsp_rand_tot_reg;
    assign rsp.rollback_total   = rsp_roll_tot_reg;

    // channel payload, written once per accepted submit
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD && can_load)
        begin
            done_mem[pos_reg] <= done_time;
            id_mem[pos_reg]   <= id_reg;
            end_mem[pos_reg]  <= end_next;
            wr_mem[pos_reg]   <= wr_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_reg      <= 6'd32;
            speed_reg     <= SPEED_W'(1);
            vld_reg       <= '0;
            frontier_reg  <= '0;
            seq_cnt_reg   <= '0;
            rand_cnt_reg  <= '0;
            roll_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_CHANNELS: chan_reg  <= cfg.data[5:0];
                    REG_SPEED:    speed_reg <= cfg.data;
                    default:      ;
                endcase
            end

            if (rsp.ready && !rsp_load)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        time_reg   <= req.request_time;
                        wr_reg     <= req.is_write;
                        sector_reg <= req.start_sector;
                        count_reg  <= req.sector_count;
                        id_reg     <= req.io_id;
                        scan_reg   <= '0;
                        found_reg  <= 1'b0;
                        seq_reg    <= 1'b0;
                        tie_reg    <= '0;
                        best_reg   <= '0;
                        pos_reg    <= '0;
                        case (req.command)
                            CMD_CLEAR:  state_reg <= S_CLEAR;
                            CMD_SUBMIT: state_reg <= S_SCAN;
                            CMD_QUERY:  state_reg <= S_QSCAN;
                            default:    state_reg <= S_IDLE;
                        endcase
                    end
                end

                // earliest channel and sequential match, one channel a cycle
                S_SCAN:
                begin
                    if (scan_reg == n_act)
                        state_reg <= S_CHECK;
                    else
                    begin
                        if (!found_reg || rd_done < best_reg)
                        begin
                            best_reg <= rd_done;
                            pos_reg  <= idx;
                        end
                        found_reg <= 1'b1;
                        if (rd_wr == wr_reg && rd_end == {1'b0, sector_reg})
                            seq_reg <= 1'b1;
                        scan_reg <= scan_reg + 1'b1;
                    end
                end

                S_CHECK:
                begin
                    if (!found_reg || best_reg >= time_reg ||
                        count_reg > 8'(MAX_SECTORS))
                    begin
                        if (can_load)
                        begin
                            rsp_valid_reg    <= 1'b1;
                            rsp_status_reg   <= (!found_reg || best_reg >= time_reg)
                                                ? ST_BUSY : ST_SIZE;
                            rsp_seq_reg      <= 1'b0;
                            rsp_time_reg     <= '0;
                            rsp_id_reg       <= '0;
                            rsp_count_reg    <= '0;
                            rsp_last_reg     <= 1'b1;
                            rsp_seq_tot_reg  <= '0;
                            rsp_rand_tot_reg <= '0;
                            rsp_roll_tot_reg <= '0;
                            state_reg        <= S_IDLE;
                        end
                    end
                    else
                    begin
                        lat_reg   <= LAT_W'(LAT_TABLE[{seq_reg, wr_reg, size_cls}]);
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    prod_reg  <= PROD_W'(lat_reg) * PROD_W'(speed_reg);
                    state_reg <= S_ADD;
                end

                S_ADD:
                begin
                    if (can_load)
                    begin
                        vld_reg[pos_reg] <= 1'b1;
                        if (seq_reg)
                            seq_cnt_reg <= (&seq_cnt_reg) ? seq_cnt_reg : seq_cnt_reg + 1'b1;
                        else
                            rand_cnt_reg <= (&rand_cnt_reg) ? rand_cnt_reg
                                                            : rand_cnt_reg + 1'b1;
                        if (time_reg < frontier_reg && !(&roll_cnt_reg))
                            roll_cnt_reg <= roll_cnt_reg + 1'b1;
                        if (done_time > frontier_reg)
                            frontier_reg <= done_time;
                        rsp_valid_reg    <= 1'b1;
                        rsp_status_reg   <= ST_OK;
                        rsp_seq_reg      <= seq_reg;
                        rsp_time_reg     <= done_time;
                        rsp_id_reg       <= id_reg;
                        rsp_count_reg    <= '0;
                        rsp_last_reg     <= 1'b1;
                        rsp_seq_tot_reg  <= '0;
                        rsp_rand_tot_reg <= '0;
                        rsp_roll_tot_reg <= '0;
                        state_reg        <= S_IDLE;
                    end
                end

                // next completion time after now, counting ties
                S_QSCAN:
                begin
                    if (scan_reg == n_act)
                    begin
                        if (!found_reg)
                        begin
                            if (can_load)
                            begin
                                rsp_valid_reg    <= 1'b1;
                                rsp_status_reg   <= ST_OK;
                                rsp_seq_reg      <= 1'b0;
                                rsp_time_reg     <= '0;
                                rsp_id_reg       <= '0;
                                rsp_count_reg    <= '0;
                                rsp_last_reg     <= 1'b1;
                                rsp_seq_tot_reg  <= '0;
                                rsp_rand_tot_reg <= '0;
                                rsp_roll_tot_reg <= '0;
                                state_reg        <= S_IDLE;
                            end
                        end
                        else
                        begin
                            k_reg        <= k_next;
                            emit_cnt_reg <= '0;
                            scan_reg     <= '0;
                            state_reg    <= S_QEMIT;
                        end
                    end
                    else
                    begin
                        if (rd_done > time_reg && (!found_reg || rd_done < best_reg))
                        begin
                            best_reg  <= rd_done;
                            found_reg <= 1'b1;
                            tie_reg   <= CNT_W'(1);
                        end
                        else if (found_reg && rd_done == best_reg)
                            tie_reg <= tie_reg + 1'b1;
                        scan_reg <= scan_reg + 1'b1;
                    end
                end

                // list ids completing at the next time, in channel order
                S_QEMIT:
                begin
                    if (rd_done == best_reg)
                    begin
                        if (can_load)
                        begin
                            rsp_valid_reg    <= 1'b1;
                            rsp_status_reg   <= ST_OK;
                            rsp_seq_reg      <= 1'b0;
                            rsp_time_reg     <= best_reg;
                            rsp_id_reg       <= vld_reg[idx] ? id_mem[idx] : '0;
                            rsp_count_reg    <= 6'(k_reg);
                            rsp_last_reg     <= (emit_cnt_reg + 1'b1 == k_reg);
                            rsp_seq_tot_reg  <= '0;
                            rsp_rand_tot_reg <= '0;
                            rsp_roll_tot_reg <= '0;
                            emit_cnt_reg     <= emit_cnt_reg + 1'b1;
                            scan_reg         <= scan_reg + 1'b1;
                            if (emit_cnt_reg + 1'b1 == k_reg)
                                state_reg <= S_IDLE;
                        end
                    end
                    else
                        scan_reg <= scan_reg + 1'b1;
                end

                // report totals, then wipe channels and counters
                S_CLEAR:
                begin
                    if (can_load)
                    begin
                        rsp_valid_reg    <= 1'b1;
                        rsp_status_reg   <= ST_OK;
                        rsp_seq_reg      <= 1'b0;
                        rsp_time_reg     <= '0;
                        rsp_id_reg       <= '0;
                        rsp_count_reg    <= '0;
                        rsp_last_reg     <= 1'b1;
                        rsp_seq_tot_reg  <= seq_cnt_reg;
                        rsp_rand_tot_reg <= rand_cnt_reg;
                        rsp_roll_tot_reg <= roll_cnt_reg;
                        vld_reg          <= '0;
                        frontier_reg     <= '0;
                        seq_cnt_reg      <= '0;
                        rand_cnt_reg     <= '0;
                        roll_cnt_reg     <= '0;
                        state_reg        <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_QEMIT |-> emit_cnt_reg < k_reg)
        else $error("query listing ran past its count");

    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_status_reg != ST_OK |-> rsp_last_reg && rsp_time_reg == '0)
        else $error("refused submit carries a time or is not last");

    a_frontier_mono: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CLEAR |=> frontier_reg >= $past(frontier_reg))
        else $error("frontier time went backwards without clear");
`endif

endmodule
